@@ sv/b64e_pkg.sv @@
package b64e_pkg;

   // queue between front and back, in jobs of up to four characters
   localparam int QUEUE_DEPTH_DEF = 4;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_URL_ALPHABET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EMIT_PADDING = 2'd1;

   localparam int SEXTET_W = 6;
   localparam int JOB_SYMS = 4;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_word_type;

   // one pending character: a sextet code or a pad
   typedef struct packed {
      logic                is_pad;
      logic [SEXTET_W-1:0] sextet;
   } sym_type;

   // everything one input byte turns into
   typedef struct packed {
      sym_type [JOB_SYMS-1:0] syms;
      logic [1:0]             count_m1;
      logic                   last;
   } job_type;

   // group position, one-hot
   typedef enum logic [2:0] {
      PH0 = 3'b001,
      PH1 = 3'b010,
      PH2 = 3'b100
   } phase_type;

endpackage

@@ sv/b64e_front.sv @@
module b64e_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  q_full,
   input  b64e_pkg::req_word_type req_word,
   input  logic                  emit_padding,
   output logic                  q_push,
   output b64e_pkg::job_type     q_job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [b64e_pkg::SEXTET_W-1:0] carry_ff, carry_in;
   logic [7:0] b;

   localparam b64e_pkg::sym_type PAD_SYM = '{is_pad: 1'b1, sextet: '0};

   assign b      = req_word.data_byte;
   assign q_push = req_push & ~q_full;

   // split the byte into sextets and work out the flush on the last byte
   always_comb begin
      q_job    = '0;
      phase_in = phase_ff;
      carry_in = carry_ff;
      case (phase_ff)
         b64e_pkg::PH1: begin
            q_job.syms[0].sextet = carry_ff | {2'b00, b[7:4]};
            carry_in = {b[3:0], 2'b00};
            phase_in = b64e_pkg::PH2;
         end
         b64e_pkg::PH2: begin
            q_job.syms[0].sextet = carry_ff | {4'b0000, b[7:6]};
            q_job.syms[1].sextet = b[5:0];
            q_job.count_m1 = 2'd1;
            carry_in = '0;
            phase_in = b64e_pkg::PH0;
         end
         default: begin
            q_job.syms[0].sextet = b[7:2];
            carry_in = {b[1:0], 4'b0000};
            phase_in = b64e_pkg::PH1;
         end
      endcase
      if (req_word.last_byte) begin
         q_job.last = 1'b1;
         case (phase_in)
            b64e_pkg::PH1: begin
               q_job.syms[1].sextet = carry_in;
               if (emit_padding) begin
                  q_job.syms[2] = PAD_SYM;
                  q_job.syms[3] = PAD_SYM;
                  q_job.count_m1 = 2'd3;
               end else begin
                  q_job.count_m1 = 2'd1;
               end
            end
            b64e_pkg::PH2: begin
               q_job.syms[1].sextet = carry_in;
               if (emit_padding) begin
                  q_job.syms[2] = PAD_SYM;
                  q_job.count_m1 = 2'd2;
               end else begin
                  q_job.count_m1 = 2'd1;
               end
            end
            default: begin
               // group already complete, nothing to flush
            end
         endcase
         phase_in = b64e_pkg::PH0;
         carry_in = '0;
      end
   end

   // group state advances on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PH0;
         carry_ff <= '0;
      end else if (q_push) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

@@ sv/b64e_queue.sv @@
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output b64e_pkg::job_type head,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64e_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/b64e_back.sv @@
module b64e_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   url_alphabet,
   input  logic                   q_empty,
   input  b64e_pkg::job_type      q_head,
   output logic                   q_pop,
   output b64e_pkg::rsp_word_type rsp_word,
   output logic                   rsp_empty,
   input  logic                   rsp_pop
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   b64e_pkg::rsp_word_type rsp_ff, rsp_in;
   b64e_pkg::sym_type sym;
   logic       load;
   logic       at_end;

   // sextet code to ascii
   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] c;
      c = 8'h00;
      case (v) inside
         [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         c = url ? 8'h2D : 8'h2B;
         default:       c = url ? 8'h5F : 8'h2F;
      endcase
      return c;
   endfunction

   assign sym    = q_head.syms[idx_ff];
   assign at_end = (idx_ff == q_head.count_m1);
   assign load   = ~q_empty & (~valid_ff | rsp_pop);
   assign q_pop  = load & at_end;

   // next character out of the head job
   always_comb begin
      rsp_in.out_char = sym.is_pad ? b64e_pkg::PAD_CHAR : sextet_char(sym.sextet, url_alphabet);
      rsp_in.out_last = q_head.last & at_end;
      idx_in   = at_end ? 2'd0 : idx_ff + 2'd1;
      valid_in = load | (valid_ff & ~rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word  = rsp_ff;
   assign rsp_empty = ~valid_ff;

endmodule

@@ sv/base64_stream_encoder_core.sv @@
// path: each accepted byte becomes a job in the queue, read out into the output register
// throughput: a byte can be taken every cycle while the job queue has room; characters leave
//   at one per cycle from the output register while the receiver pops, so a steady stream
//   runs at 4 characters per 3 bytes, and a last byte adds up to 3 more characters
// reset: synchronous, active high; empties the queue and output, restarts the group,
//   selects the standard alphabet and turns padding on
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  b64e_pkg::req_word_type              req_word,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output b64e_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [b64e_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [b64e_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic url_alphabet_ff;
   logic emit_padding_ff;
   logic q_push, q_pop, q_full, q_empty;
   b64e_pkg::job_type q_job, q_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b0;
         emit_padding_ff <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == b64e_pkg::CSR_URL_ALPHABET) begin
            url_alphabet_ff <= csr_data[0];
         end else if (csr_index == b64e_pkg::CSR_EMIT_PADDING) begin
            emit_padding_ff <= csr_data[0];
         end
      end
   end

   assign req_full = q_full;

   b64e_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .q_full       (q_full),
      .req_word     (req_word),
      .emit_padding (emit_padding_ff),
      .q_push       (q_push),
      .q_job        (q_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .url_alphabet (url_alphabet_ff),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_word     (rsp_word),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop)
   );

endmodule

@@ sv/b64e_checker.sv @@
module b64e_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_full,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input b64e_pkg::rsp_word_type           rsp_word
);

   logic [7:0] c;
   assign c = rsp_word.out_char;

   // reset leaves both sides open and nothing waiting
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not clear after reset");

   // a waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("result word changed before pop");

   // every character is from an alphabet or a pad
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                      (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                      c == 8'h2D || c == 8'h5F || c == b64e_pkg::PAD_CHAR))
      else $error("illegal output character");

   // a pad is followed straight away by another pad until the message ends
   a_pad_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && c == b64e_pkg::PAD_CHAR && !rsp_word.out_last)
      |=> (!rsp_empty && rsp_word.out_char == b64e_pkg::PAD_CHAR))
      else $error("pad run broken");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (.*);

@@ test/base64_stream_encoder_core_test.sv @@
module base64_stream_encoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes the block has no register behind
   localparam logic [b64e_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [b64e_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int HOLD_CYCLES  = 120;
   localparam int LIMIT_CYCLES = 200000;

   // encoder state mirror and queue of characters still owed by the block
   class b64_scoreboard;
      bit                     url_sel;
      bit                     pad_en;
      bit [1:0]               phase;
      bit [5:0]               carry;
      b64e_pkg::rsp_word_type due_q[$];
      int                     mismatches;
      int                     chars_checked;
      int                     bytes_seen;
      int                     messages;

      function new();
         url_sel = 1'b0;
         pad_en  = 1'b1;
         phase   = 2'd0;
         carry   = 6'd0;
         mismatches = 0;
         chars_checked = 0;
         bytes_seen = 0;
         messages = 0;
      endfunction

      function void write_reg(logic [b64e_pkg::CSR_INDEX_W-1:0] idx,
                              logic [b64e_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            b64e_pkg::CSR_URL_ALPHABET: url_sel = val[0];
            b64e_pkg::CSR_EMIT_PADDING: pad_en = val[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] sextet_ascii(bit [5:0] v);
         if (v < 26) return 8'("A") + 8'(v);
         else if (v < 52) return 8'("a") + 8'(v) - 8'd26;
         else if (v < 62) return 8'("0") + 8'(v) - 8'd52;
         else if (v == 62) return url_sel ? 8'("-") : 8'("+");
         else return url_sel ? 8'("_") : 8'("/");
      endfunction

      // work out the characters one accepted word turns into
      function void note_byte(b64e_pkg::req_word_type w);
         logic [7:0]             chars[$];
         bit [1:0]               ph;
         b64e_pkg::rsp_word_type e;
         ph = (phase == 2'd3) ? 2'd0 : phase;
         bytes_seen++;
         case (ph)
            2'd0: begin
               chars.push_back(sextet_ascii(w.data_byte[7:2]));
               carry = {w.data_byte[1:0], 4'b0000};
               ph = 2'd1;
            end
            2'd1: begin
               chars.push_back(sextet_ascii(carry | {2'b00, w.data_byte[7:4]}));
               carry = {w.data_byte[3:0], 2'b00};
               ph = 2'd2;
            end
            default: begin
               chars.push_back(sextet_ascii(carry | {4'b0000, w.data_byte[7:6]}));
               chars.push_back(sextet_ascii(w.data_byte[5:0]));
               carry = 6'd0;
               ph = 2'd0;
            end
         endcase
         // flush the partial sextet, then pad out the group when padding is on
         if (w.last_byte) begin
            if (ph != 2'd0) begin
               chars.push_back(sextet_ascii(carry));
               if (pad_en)
                  repeat (3 - ph) chars.push_back(b64e_pkg::PAD_CHAR);
            end
            ph = 2'd0;
            carry = 6'd0;
            messages++;
         end
         phase = ph;
         foreach (chars[i]) begin
            e.out_char = chars[i];
            e.out_last = w.last_byte && (i == chars.size() - 1);
            due_q.push_back(e);
         end
      endfunction

      function void check_char(b64e_pkg::rsp_word_type got);
         b64e_pkg::rsp_word_type e;
         if (due_q.size() == 0) begin
            $error("character %h with no expectation waiting", got.out_char);
            mismatches++;
            return;
         end
         e = due_q.pop_front();
         chars_checked++;
         if (got.out_char !== e.out_char) begin
            $error("out_char expected %h actual %h", e.out_char, got.out_char);
            mismatches++;
         end
         if (got.out_last !== e.out_last) begin
            $error("out_last expected %b actual %b", e.out_last, got.out_last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   b64e_pkg::req_word_type req_word = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   b64e_pkg::rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [b64e_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [b64e_pkg::CSR_DATA_W-1:0] csr_data = '0;

   b64_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_armed = 1'b0;
   int hold_count = 0;
   int cycle_count = 0;

   base64_stream_encoder_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("base64_stream_encoder_core verification failed");
         $finish;
      end
   end

   // receiver: check accepted words, then pick next pop, with one long hold-off
   always @(posedge clock) begin
      if (rsp_pop && !rsp_empty)
         sb.check_char(rsp_word);
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic b64e_pkg::req_word_type pack_byte(logic [7:0] b, logic l);
      b64e_pkg::req_word_type w;
      w.data_byte = b;
      w.last_byte = l;
      return w;
   endfunction

   // offer one word after a random gap and wait until it is taken
   task automatic send_byte(input b64e_pkg::req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         req_word <= b64e_pkg::req_word_type'($urandom);
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_byte(w);
   endtask

   // one message of random length, biased toward edge byte values
   task automatic send_message(output int len);
      logic [7:0] b;
      len = ($urandom_range(9) < 8) ? $urandom_range(6, 1) : $urandom_range(16, 7);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(4))
               0: b = 8'h00;
               1: b = 8'hFF;
               2: b = 8'hFB;
               3: b = 8'hFC;
               default: b = 8'h03;
            endcase
         end else begin
            b = 8'($urandom);
         end
         send_byte(pack_byte(b, i == len - 1));
      end
   endtask

   task automatic write_reg(input logic [b64e_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [b64e_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   // set both registers, upper value bits random, plus writes to unused indexes
   task automatic set_encoding(input bit url, input bit pad);
      write_reg(CSR_SPARE_A, 8'($urandom));
      write_reg(b64e_pkg::CSR_URL_ALPHABET, {7'($urandom_range(127)), url});
      write_reg(b64e_pkg::CSR_EMIT_PADDING, {7'($urandom_range(127)), pad});
      write_reg(CSR_SPARE_B, 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic send_random(input int n);
      int sent;
      int len;
      sent = 0;
      while (sent < n) begin
         send_message(len);
         sent += len;
      end
   endtask

   initial begin
      logic [7:0] dir_bytes[$];
      int         dir_lens[$];
      int         k;
      sb = new();
      // single bytes, codes 62 and 63, a full group as the last one, longer runs
      dir_bytes = '{8'h00, 8'hFF, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h00,
                    8'h4D, 8'h61, 8'h6E, 8'h41, 8'h42, 8'h80, 8'h01};
      dir_lens = '{1, 1, 2, 3, 4, 5, 2};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under reset settings
      send_idle_pct = 13;
      recv_idle_pct = 64;
      k = 0;
      foreach (dir_lens[m]) begin
         for (int i = 0; i < dir_lens[m]; i++) begin
            send_byte(pack_byte(dir_bytes[k], i == dir_lens[m] - 1));
            k++;
         end
      end
      drain();

      // url alphabet without padding, receiver stalls long enough to back up the queue
      set_encoding(1'b1, 1'b0);
      hold_armed = 1'b1;
      send_random(120);
      drain();

      // standard alphabet without padding, busy sender side swapped
      send_idle_pct = 64;
      recv_idle_pct = 13;
      set_encoding(1'b0, 1'b0);
      send_random(130);
      drain();

      // url alphabet with padding, both sides at full rate
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_encoding(1'b1, 1'b1);
      send_random(130);
      drain();

      $display("covered %0d bytes in %0d messages, %0d characters checked,",
               sb.bytes_seen, sb.messages, sb.chars_checked);
      $display("all four alphabet and padding settings, stalls on both sides");
      if (sb.due_q.size() != 0) begin
         $error("%0d expected characters never arrived", sb.due_q.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0)
         $display("base64_stream_encoder_core verification clean");
      else
         $display("base64_stream_encoder_core verification failed");
      $finish;
   end

endmodule
